### design/fxd_pkg.sv
// ----------------------------------------------------------------------------
// fxd_pkg: shared types and constants of the framed XY to DAC receiver
// Holds the operation codes, register indexes, parser phases, item and
// result structures, and the DAC command word builder.
// ----------------------------------------------------------------------------
package fxd_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_ERROR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_HOLDOFF = 1'b1;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] HOLDOFF_RESET = 16'd2000;

    // Frame constants.
    localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
    localparam logic [7:0]  CMD_A       = 8'h30;
    localparam logic [7:0]  CMD_B       = 8'hB0;
    localparam logic [15:0] SIGN_FLIP   = 16'h8000;
    localparam logic [7:0]  PAYLOAD_LEN = 8'd4;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    // One input item.
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [15:0] chan_a_word;
        logic [15:0] chan_b_word;
        logic        from_timeout;
    } result_t;

    // Builds a DAC command: command nibble on top, then the upper 12 bits of
    // the sample with its sign bit flipped to offset binary.
    function automatic logic [15:0] dac_word(input logic [7:0] cmd,
                                             input logic [15:0] value);
        logic [15:0] flipped;
        flipped  = value ^ SIGN_FLIP;
        dac_word = {cmd, 8'h00} | {4'h0, flipped[15:4]};
    endfunction

endpackage

### design/framed_xy_to_dac_receiver_top.sv
// ----------------------------------------------------------------------------
// framed_xy_to_dac_receiver_top: framed XY receiver with DAC command output
// Parses sync/length/payload/checksum frames and turns valid XY frames and
// watchdog timeouts into pairs of DAC command words.
// ----------------------------------------------------------------------------
// The block takes one item (a byte, a receive error mark or a tick) in every
// clock cycle while in_stall is low. An accepted item sits in the input
// register while the parser logic works on it; when the pipeline advances,
// its result, if any, loads into the result register that drives the output.
// A waiting result holds the result register, and the input register still
// takes one more item behind it before in_stall rises.
// Configuration writes take effect at the next clock edge and should be made
// only while no item is in flight.
module framed_xy_to_dac_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] chan_a_word,
    output logic [15:0] chan_b_word,
    output logic        from_timeout
);

    logic             advance;
    logic             item_valid;
    fxd_pkg::item_t   item;
    logic             res_valid;
    fxd_pkg::result_t res;
    fxd_pkg::result_t out_res;

    // Input register.
    fxd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parser, watchdog and configuration registers.
    fxd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (item_valid && advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    fxd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign chan_a_word  = out_res.chan_a_word;
    assign chan_b_word  = out_res.chan_b_word;
    assign from_timeout = out_res.from_timeout;

endmodule

### design/fxd_in_stage.sv
// ----------------------------------------------------------------------------
// fxd_in_stage: input register
// Captures one item per cycle and holds it while the result side is stalled.
// ----------------------------------------------------------------------------
module fxd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      operation,
    input  logic [7:0]      rx_byte,
    input  logic            advance,
    output logic            item_valid,
    output fxd_pkg::item_t  item
);

    logic           item_valid_reg;
    logic           item_valid_next;
    fxd_pkg::item_t item_reg;
    logic           load;

    // The register frees up whenever its item moves on to the parser.
    assign in_stall = item_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (!in_stall)
        begin
            item_valid_next = in_valid;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.operation <= operation;
            item_reg.rx_byte   <= rx_byte;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

### design/fxd_parser.sv
// ----------------------------------------------------------------------------
// fxd_parser: frame parser and watchdog
// Holds the parser state, payload bytes, watchdog and holdoff counters and
// the two configuration registers, and works out the result of one item.
// ----------------------------------------------------------------------------
module fxd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             fire,
    input  fxd_pkg::item_t   item,
    output logic             res_valid,
    output fxd_pkg::result_t res
);

    fxd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  payload_reg [4];
    logic        store_en;
    logic [15:0] watchdog_reg, watchdog_next;
    logic [15:0] holdoff_cnt_reg, holdoff_cnt_next;
    logic        in_holdoff_reg, in_holdoff_next;
    logic [15:0] timeout_ticks_reg;
    logic [15:0] holdoff_ticks_reg;
    logic [15:0] watchdog_inc;
    logic [15:0] holdoff_inc;
    logic [7:0]  count_inc;

    // Saturating tick counters and the payload byte counter.
    assign watchdog_inc = (watchdog_reg < fxd_pkg::COUNT_MAX) ? watchdog_reg + 16'd1
                                                               : watchdog_reg;
    assign holdoff_inc  = (holdoff_cnt_reg < fxd_pkg::COUNT_MAX) ? holdoff_cnt_reg + 16'd1
                                                                  : holdoff_cnt_reg;
    assign count_inc    = count_reg + 8'd1;

    // Next state and result for the item being processed.
    always_comb
    begin
        phase_next       = phase_reg;
        length_next      = length_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        store_en         = 1'b0;
        watchdog_next    = watchdog_reg;
        holdoff_cnt_next = holdoff_cnt_reg;
        in_holdoff_next  = in_holdoff_reg;
        res_valid        = 1'b0;
        res.chan_a_word  = fxd_pkg::dac_word(fxd_pkg::CMD_A,
                                             {payload_reg[0], payload_reg[1]});
        res.chan_b_word  = fxd_pkg::dac_word(fxd_pkg::CMD_B,
                                             {payload_reg[2], payload_reg[3]});
        res.from_timeout = 1'b0;
        if (fire)
        begin
            case (item.operation)
                fxd_pkg::OP_BYTE:
                begin
                    if (!in_holdoff_reg)
                    begin
                        case (phase_reg)
                            fxd_pkg::PH_SYNC1:
                            begin
                                if (item.rx_byte == fxd_pkg::SYNC_BYTE)
                                begin
                                    phase_next = fxd_pkg::PH_SYNC2;
                                end
                            end
                            fxd_pkg::PH_SYNC2:
                            begin
                                if (item.rx_byte == fxd_pkg::SYNC_BYTE)
                                begin
                                    phase_next = fxd_pkg::PH_LENGTH;
                                end
                            end
                            fxd_pkg::PH_LENGTH:
                            begin
                                if (item.rx_byte != 8'd0)
                                begin
                                    length_next = item.rx_byte;
                                    count_next  = 8'd0;
                                    sum_next    = 8'd0;
                                    phase_next  = fxd_pkg::PH_PAYLOAD;
                                end
                                else
                                begin
                                    phase_next = fxd_pkg::PH_SYNC1;
                                end
                            end
                            fxd_pkg::PH_PAYLOAD:
                            begin
                                // Only the first four payload bytes are kept.
                                store_en   = (count_reg < fxd_pkg::PAYLOAD_LEN);
                                count_next = count_inc;
                                sum_next   = sum_reg + item.rx_byte;
                                if (count_inc == length_reg)
                                begin
                                    phase_next = fxd_pkg::PH_CHECK;
                                end
                            end
                            fxd_pkg::PH_CHECK:
                            begin
                                phase_next = fxd_pkg::PH_SYNC1;
                                if (sum_reg == item.rx_byte &&
                                    length_reg == fxd_pkg::PAYLOAD_LEN)
                                begin
                                    res_valid     = 1'b1;
                                    watchdog_next = 16'd0;
                                end
                            end
                            default:
                            begin
                                phase_next = fxd_pkg::PH_SYNC1;
                            end
                        endcase
                    end
                end
                fxd_pkg::OP_ERROR:
                begin
                    if (!in_holdoff_reg)
                    begin
                        phase_next = fxd_pkg::PH_SYNC1;
                    end
                end
                fxd_pkg::OP_TICK:
                begin
                    if (in_holdoff_reg)
                    begin
                        holdoff_cnt_next = holdoff_inc;
                        if (holdoff_inc >= holdoff_ticks_reg)
                        begin
                            in_holdoff_next  = 1'b0;
                            holdoff_cnt_next = 16'd0;
                            watchdog_next    = 16'd0;
                        end
                    end
                    else
                    begin
                        watchdog_next = watchdog_inc;
                        if (watchdog_inc >= timeout_ticks_reg)
                        begin
                            // Watchdog timeout: centre both channels.
                            watchdog_next    = 16'd0;
                            holdoff_cnt_next = 16'd0;
                            in_holdoff_next  = (holdoff_ticks_reg != 16'd0);
                            res_valid        = 1'b1;
                            res.chan_a_word  = fxd_pkg::dac_word(fxd_pkg::CMD_A, 16'd0);
                            res.chan_b_word  = fxd_pkg::dac_word(fxd_pkg::CMD_B, 16'd0);
                            res.from_timeout = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= fxd_pkg::PH_SYNC1;
            length_reg        <= 8'd0;
            count_reg         <= 8'd0;
            sum_reg           <= 8'd0;
            watchdog_reg      <= 16'd0;
            holdoff_cnt_reg   <= 16'd0;
            in_holdoff_reg    <= 1'b0;
            timeout_ticks_reg <= fxd_pkg::TIMEOUT_RESET;
            holdoff_ticks_reg <= fxd_pkg::HOLDOFF_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            length_reg      <= length_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            watchdog_reg    <= watchdog_next;
            holdoff_cnt_reg <= holdoff_cnt_next;
            in_holdoff_reg  <= in_holdoff_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    fxd_pkg::CFG_TIMEOUT: timeout_ticks_reg <= cfg_data;
                    fxd_pkg::CFG_HOLDOFF: holdoff_ticks_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload bytes are written at the current byte position.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[count_reg[1:0]] <= item.rx_byte;
        end
    end

endmodule

### design/fxd_out_stage.sv
// ----------------------------------------------------------------------------
// fxd_out_stage: result register
// Holds one result until it is taken and tells the rest of the block when
// the pipeline may move.
// ----------------------------------------------------------------------------
module fxd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  fxd_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_stall,
    output fxd_pkg::result_t out_res
);

    logic             out_valid_reg;
    logic             out_valid_next;
    fxd_pkg::result_t res_reg;

    // The pipeline moves unless a waiting result is being held back.
    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule
